/* src/kcd_pkg.sv */
//------------------------------------------------------------------------------
// kcd_pkg
// Shared types, constants, the seed-rule function and the base lookup for
// the k-mer core detector scan chain.
//------------------------------------------------------------------------------
`default_nettype none

package kcd_pkg;

  localparam int unsigned KmerW   = 28;
  localparam int unsigned BucketW = 29;
  localparam int unsigned PosW    = 4;
  localparam int unsigned NumPos  = 12;
  localparam int unsigned NumSlot = 10;
  localparam int unsigned LastBase = 13;

  typedef logic [PosW-1:0] pos_t;

  // Scan context handed from one cell to the next
  typedef struct packed {
    logic                done;      // scan finished (hit, run stop)
    logic                run_stop;
    logic [BucketW-1:0]  bucket;
    pos_t                core_start;
    pos_t                core_end;
    logic [KmerW-1:0]    kmer;
    logic [7:0]          marker;
    logic [2:0]          cnt;
    pos_t [NumSlot-1:0]  s_start;
    logic [NumSlot-1:0]  s_ok;
    pos_t [NumSlot-1:0]  s_end;
  } scan_t;

  // Seed table rules on a four-digit marker group
  function automatic logic seed_hit(input logic [7:0] i);
    logic [1:0] a, b, c, d;
    a = i[7:6]; b = i[5:4]; c = i[3:2]; d = i[1:0];
    seed_hit = (a < b && b > c) || (b == c && a != b && b != d) ||
               (a != b && b < c && c < d) || (a == b && b == c && c != d);
  endfunction

  // Base at position p, zero past the end
  function automatic logic [1:0] base_at(input logic [KmerW-1:0] k, input logic [4:0] p);
    logic [5:0] sh;
    sh = 6'(2 * (5'(LastBase) - p));
    base_at = (p > 5'(LastBase)) ? 2'd0 : 2'(k >> sh);
  endfunction

endpackage

`default_nettype wire

/* src/kcd_cell.sv */
//------------------------------------------------------------------------------
// kcd_cell
// One scan position: applies the six local rules at position POS, records
// the slot, tests the marker group and forwards the context to the next cell.
//------------------------------------------------------------------------------
`default_nettype none

module kcd_cell #(
  parameter int unsigned POS = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          vld_in,
  input  kcd_pkg::scan_t     ctx_in,
  output logic               vld_r,
  output kcd_pkg::scan_t     ctx_r
);
  import kcd_pkg::*;

  localparam logic [4:0] P = 5'(POS);

  scan_t ctx_nxt;

  // Report a core from slots si..ei
  function automatic scan_t do_report(input scan_t c, input logic [3:0] si,
                                      input logic [3:0] ei);
    scan_t   o;
    pos_t    s, e;
    logic [4:0]  n;
    logic [KmerW-1:0] mask, val;
    o = c;
    s = c.s_ok[si] ? c.s_start[si] : '0;
    e = (c.s_end[ei] > pos_t'(LastBase)) ? pos_t'(LastBase) : c.s_end[ei];
    val = '0;
    if (s <= e) begin
      n = 5'(e - s) + 5'd1;
      mask = (n >= 5'd14) ? '1 : KmerW'((29'd1 << (2 * n)) - 29'd1);
      val = (c.kmer >> (2 * (pos_t'(LastBase) - e))) & mask;
    end
    o.bucket = BucketW'(val) + BucketW'(1);
    o.core_start = s;
    o.core_end = e;
    o.done = 1'b1;
    return o;
  endfunction

  function automatic scan_t drop(input scan_t c, input int n);
    scan_t o;
    o = c;
    for (int k = 1; k + n < NumSlot; k++) begin
      o.s_start[4'(k)] = c.s_start[4'(k+n)];
      o.s_ok[4'(k)]    = c.s_ok[4'(k+n)];
      o.s_end[4'(k)]   = c.s_end[4'(k+n)];
    end
    return o;
  endfunction

  // Evaluate this position's rules
  always_comb begin
    logic [1:0] x, y, z, w, v, u, sym;
    logic [2:0] len, cnt;
    logic       two;
    logic [15:0] mk;
    ctx_nxt = ctx_in;
    x = base_at(ctx_in.kmer, P);
    y = base_at(ctx_in.kmer, P + 5'd1);
    z = base_at(ctx_in.kmer, P + 5'd2);
    w = base_at(ctx_in.kmer, P + 5'd3);
    v = base_at(ctx_in.kmer, P + 5'd4);
    u = base_at(ctx_in.kmer, P + 5'd5);
    len = '0; sym = y; two = 1'b0;
    cnt = ctx_in.cnt + 3'd1;
    mk = {8'd0, ctx_in.marker};
    if (!ctx_in.done) begin
      priority if (x < y && y > z) begin
        len = 3'd2;
      end else if (POS < 10 && x != y && y == z && z == w && w != v) begin
        len = 3'd4;
      end else if (POS < 11 && x < y && y == z && y > w) begin
        len = 3'd3;
      end else if (POS < 9 && x != y && y == z && z == w && w == v && v != u) begin
        len = 3'd5; two = 1'b1;
      end else if (POS < 10 && x >= y && y > z && z < w && w <= v) begin
        len = 3'd4; sym = z;
      end else if (POS < 10 && x == y && y == z && z == w && w == v) begin
        ctx_nxt.done = 1'b1;
        ctx_nxt.run_stop = 1'b1;
      end else begin
        len = '0;
      end
      if (len != 3'd0) begin
        ctx_nxt.s_start[{1'b0, cnt}] = pos_t'(POS);
        ctx_nxt.s_ok[{1'b0, cnt}]    = 1'b1;
        ctx_nxt.s_end[{1'b0, cnt}]   = pos_t'(P + 5'(len));
        if (two) begin
          ctx_nxt.s_end[{1'b0, cnt} + 4'd1] = pos_t'(P + 5'(len));
          cnt = cnt + 3'd1;
          mk = (16'(ctx_in.marker) << 4) | 16'(4'(sym) * 4'd5);
        end else begin
          mk = (16'(ctx_in.marker) << 2) | 16'(sym);
        end
        ctx_nxt.cnt = cnt;
        ctx_nxt.marker = mk[7:0];
        // Group test and window shift
        if (cnt == 3'd4) begin
          if (seed_hit(mk[7:0])) begin
            ctx_nxt = do_report(ctx_nxt, 4'd1, 4'd4);
          end else if (!ctx_nxt.s_ok[2]) begin
            ctx_nxt = drop(ctx_nxt, 2); ctx_nxt.cnt = 3'd2; ctx_nxt.marker = mk[7:0] & 8'd15;
          end else begin
            ctx_nxt = drop(ctx_nxt, 1); ctx_nxt.cnt = 3'd3; ctx_nxt.marker = mk[7:0] & 8'd63;
          end
        end else if (cnt == 3'd5) begin
          if (seed_hit(mk[9:2])) begin
            ctx_nxt = do_report(ctx_nxt, 4'd2, 4'd5);
          end else if (seed_hit(mk[7:0]) && ctx_nxt.s_ok[2]) begin
            ctx_nxt = do_report(ctx_nxt, 4'd1, 4'd4);
          end else if (!ctx_nxt.s_ok[2]) begin
            ctx_nxt = drop(ctx_nxt, 2); ctx_nxt.cnt = 3'd3; ctx_nxt.marker = mk[7:0] & 8'd31;
          end else begin
            ctx_nxt = drop(ctx_nxt, 3); ctx_nxt.cnt = 3'd2; ctx_nxt.marker = mk[7:0] & 8'd15;
          end
        end
      end
    end
  end

  // Advance the context to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r <= ctx_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/kmer_core_detector_core.sv */
//------------------------------------------------------------------------------
// kmer_core_detector_core
// Finds the seeded core of a 14-base k-mer with a chain of twelve scan cells.
//
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_kmer             | into block
//  out     | out_valid, out_stall, out_bucket,       | out of block
//          | out_core_start, out_core_end, out_run_stop
//
// One k-mer enters per cycle while in_stall is low; the chain has one cell
// per scan position. The whole chain advances together: a stall on the
// output freezes every cell and raises in_stall only when the last cell
// holds a result. Reset clears all valid bits; payload needs none.
//------------------------------------------------------------------------------
`default_nettype none

module kmer_core_detector_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [kcd_pkg::KmerW-1:0]   in_kmer,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [kcd_pkg::BucketW-1:0]      out_bucket,
  output logic [kcd_pkg::PosW-1:0]         out_core_start,
  output logic [kcd_pkg::PosW-1:0]         out_core_end,
  output logic                             out_run_stop
);
  import kcd_pkg::*;

  logic               adv;
  logic [NumPos:0]    vld;
  scan_t              ctx [NumPos+1];
  scan_t              ctx_head;

  assign adv = !(vld[NumPos] && out_stall);
  assign in_stall = !adv;

  // Clean context for a fresh k-mer
  always_comb begin
    ctx_head = '0;
    ctx_head.kmer = in_kmer;
  end

  assign ctx[0] = ctx_head;
  assign vld[0] = in_valid;

  for (genvar g = 0; g < NumPos; g++) begin : g_cell
    kcd_cell #(.POS(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_in(vld[g]), .ctx_in(ctx[g]),
      .vld_r(vld[g+1]), .ctx_r(ctx[g+1])
    );
  end

  assign out_valid      = vld[NumPos];
  assign out_bucket     = ctx[NumPos].bucket;
  assign out_core_start = ctx[NumPos].core_start;
  assign out_core_end   = ctx[NumPos].core_end;
  assign out_run_stop   = ctx[NumPos].run_stop;

  // A run stop never carries a bucket
  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_stop |-> out_bucket == '0) else $error("run stop with bucket");
  // Stall freezes the result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bucket)) else $error("result moved");
  // Input is held back only by an output stall
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid) else $error("spurious stall");
  // No hit means start and end are zero
  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bucket == '0 |-> out_core_start == '0 && out_core_end == '0)
    else $error("positions without core");

endmodule

`default_nettype wire
